FILE: hdl/srts_pkg.sv
`timescale 1ns / 1ps
package srts_pkg;
	localparam int MaxSlots = 16;
	localparam int SlotW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
	localparam int CntW = $clog2(MaxSlots + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] arrival;
		logic [7:0]  burst;
		logic [7:0]  remaining;
		logic        done;
		logic        started;
	} slot_t;

	typedef struct packed {
		logic              valid;
		logic [SlotW-1:0]  slot;
		logic [7:0]        remaining;
	} cand_t;

	typedef struct packed {
		logic        running_valid;
		logic [3:0]  running_slot;
		logic [7:0]  running_id;
		logic        resumed;
		logic        preempted;
		logic [7:0]  preempted_id;
		logic [7:0]  preempted_left;
		logic        completed;
		logic [15:0] turnaround;
		logic [15:0] waiting;
		logic [15:0] tick_time;
		logic        all_done;
	} result_t;
endpackage

FILE: hdl/srts_cell.sv
`timescale 1ns / 1ps
module srts_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load_en,
	input  logic                  clr,
	input  logic                  shift_en,
	input  srts_pkg::slot_t       load_data,
	input  srts_pkg::slot_t       shift_in,
	output srts_pkg::slot_t       cell_q
);
	import srts_pkg::*;

	slot_t data_q;
	logic  done_q;
	logic  started_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= shift_in;
		end else if (load_en) begin
			data_q <= load_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (shift_en) begin
			done_q    <= shift_in.done;
			started_q <= shift_in.started;
		end else if (clr) begin
			done_q    <= 1'b0;
			started_q <= 1'b0;
		end
	end

	always_comb begin
		cell_q         = data_q;
		cell_q.done    = done_q;
		cell_q.started = started_q;
	end
endmodule

FILE: hdl/shortest_remaining_time_scheduler.sv
`timescale 1ns / 1ps
// A load beat gives no output beat. A tick beat is taken only while the block is idle. The
// slot table is a ring of cells that rotates one place a cycle, during the two laps of a
// tick, past a single compare unit. One lap chooses the slot, and a second lap updates the
// chosen slot and builds the result, which is then offered as the result beat. The next
// beat can be taken in the cycle after the result beat is taken.
module shortest_remaining_time_scheduler (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // slot, tid, arrival, burst, zero fill
	input  logic         s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,  // running_valid, running_slot, running_id, resumed,
	                               // preempted, preempted_id, preempted_left, completed,
	                               // turnaround, waiting, tick_time, all_done, zero fill
	input  logic         cfg_we,
	input  logic [4:0]   cfg_wdata
);
	import srts_pkg::*;

	state_t state_q, state_d;
	slot_t  cells [MaxSlots];
	slot_t  fb;
	slot_t  ld;
	logic   shift_en, clr, fin_en;
	logic [4:0]       tc_q;
	logic [CntW-1:0]  n_run;
	logic [SlotW-1:0] pos_q;
	logic [15:0]      now_q;
	logic             last_valid_q;
	logic [SlotW-1:0] last_slot_q;
	cand_t            best_q;
	logic             alldone_q;
	result_t          res_q;
	logic             s_acc, m_acc;
	logic [3:0]       in_slot;

	assign in_slot = s_tdata[3:0];
	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;
	assign n_run = (tc_q > 5'(MaxSlots)) ? CntW'(MaxSlots) : CntW'(tc_q);

	always_comb begin
		ld = '0;
		ld.id = s_tdata[11:4];
		ld.arrival = s_tdata[27:12];
		ld.burst = s_tdata[35:28];
		ld.remaining = s_tdata[35:28];
	end

	logic in_run;
	logic elig;
	slot_t head;
	assign head = cells[0];
	assign in_run = ({1'b0, pos_q} < (SlotW+1)'(n_run));
	assign elig = in_run && !head.done && (head.arrival <= now_q);

	// writeback of the chosen slot as it passes the head during fin lap
	always_comb begin
		fb = head;
		if (fin_en && best_q.valid && pos_q == best_q.slot) begin
			fb.started = 1'b1;
			if (head.remaining != 8'd0) fb.remaining = head.remaining - 8'd1;
			if (head.remaining <= 8'd1) fb.done = 1'b1;
		end
	end

	genvar g;
	generate
		for (g = 0; g < MaxSlots; g++) begin : g_cell
			srts_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.load_en(s_acc && !s_tuser && ({1'b0, in_slot} == 5'(g))),
				.clr(clr),
				.shift_en(shift_en),
				.load_data(ld),
				.shift_in((g == MaxSlots-1) ? fb : cells[(g+1) % MaxSlots]),
				.cell_q(cells[g])
			);
		end
	endgenerate

	logic load_ok;
	assign load_ok = ({1'b0, in_slot} < 5'(MaxSlots));
	assign clr = s_acc && !s_tuser && load_ok;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_acc && s_tuser) state_d = ST_SCAN;
			ST_SCAN: if (pos_q == SlotW'(MaxSlots-1)) state_d = ST_FIN;
			ST_FIN:  if (pos_q == SlotW'(MaxSlots-1)) state_d = ST_OUT;
			ST_OUT:  if (m_acc) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		shift_en = 1'b0;
		fin_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: shift_en = 1'b1;
			ST_FIN: begin
				shift_en = 1'b1;
				fin_en = 1'b1;
			end
			ST_OUT:  m_tvalid = 1'b1;
			default: ;
		endcase
	end

	logic [15:0] now_inc;
	logic [15:0] turn_w;
	logic [15:0] wait_w;
	assign now_inc = (now_q == 16'hFFFF) ? now_q : now_q + 16'd1;
	assign turn_w = now_inc - head.arrival;
	assign wait_w = (turn_w[15:0] >= {8'd0, head.burst}) ? turn_w[15:0] - {8'd0, head.burst}
		: 16'd0;

	function automatic logic alldone_after(input logic [CntW-1:0] n,
		input slot_t c [MaxSlots], input cand_t b, input slot_t f,
		input logic [SlotW-1:0] p);
		logic r;
		r = 1'b1;
		for (int k = 0; k < MaxSlots; k++) begin
			if (k < int'(n)) begin
				if (k == MaxSlots-1) begin
					if (!f.done) r = 1'b0;
				end else if (!c[k+1].done) r = 1'b0;
			end
		end
		if (p != SlotW'(MaxSlots-1)) r = 1'b0;
		if (!b.valid && n != '0 && r == 1'b0) r = 1'b0;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tc_q <= 5'd16;
			pos_q <= '0;
			now_q <= '0;
			last_valid_q <= 1'b0;
			last_slot_q <= '0;
			best_q <= '0;
			alldone_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) tc_q <= cfg_wdata;
			if (clr) begin
				now_q <= '0;
				last_valid_q <= 1'b0;
				last_slot_q <= '0;
			end
			if (shift_en) pos_q <= pos_q + SlotW'(1);
			if (state_q == ST_IDLE && s_acc && s_tuser) begin
				pos_q <= '0;
				best_q <= '0;
				alldone_q <= 1'b1;
			end
			if (state_q == ST_SCAN) begin
				if (in_run && !head.done) alldone_q <= 1'b0;
				if (elig && (!best_q.valid || head.remaining < best_q.remaining)) begin
					best_q.valid <= 1'b1;
					best_q.slot <= pos_q;
					best_q.remaining <= head.remaining;
				end
			end
			if (state_q == ST_FIN && pos_q == SlotW'(MaxSlots-1) && !alldone_q) begin
				now_q <= now_inc;
				last_valid_q <= best_q.valid;
				last_slot_q <= best_q.valid ? best_q.slot : last_slot_q;
			end
		end
	end

	// result assembly during fin lap, cleared when the scan lap starts
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && pos_q == '0) begin
			res_q <= '0;
		end
		if (fin_en) begin
			if (pos_q == '0) begin
				res_q.tick_time <= now_q;
				res_q.all_done <= alldone_q;
				res_q.running_valid <= best_q.valid && !alldone_q;
			end
			if (!alldone_q && last_valid_q && pos_q == last_slot_q &&
				(!best_q.valid || last_slot_q != best_q.slot) && head.remaining != 8'd0) begin
				res_q.preempted <= 1'b1;
				res_q.preempted_id <= head.id;
				res_q.preempted_left <= head.remaining;
			end
			if (!alldone_q && best_q.valid && pos_q == best_q.slot) begin
				res_q.running_slot <= 4'(pos_q);
				res_q.running_id <= head.id;
				res_q.resumed <= !head.started || !last_valid_q || last_slot_q != pos_q;
				if (head.remaining <= 8'd1) begin
					res_q.completed <= 1'b1;
					res_q.turnaround <= turn_w[15:0];
					res_q.waiting <= wait_w;
				end
			end
			if (pos_q == SlotW'(MaxSlots-1) && !alldone_q) begin
				res_q.all_done <= alldone_after(n_run, cells, best_q, fb, pos_q);
			end
		end
	end

	assign m_tdata = {7'b0, res_q.all_done, res_q.tick_time, res_q.waiting,
		res_q.turnaround, res_q.completed, res_q.preempted_left, res_q.preempted_id,
		res_q.preempted, res_q.resumed, res_q.running_id, res_q.running_slot,
		res_q.running_valid};

	logic unused;
	assign unused = ^s_tdata[39:36];
endmodule

FILE: hdl/srts_checker.sv
`timescale 1ns / 1ps
module srts_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [87:0]  m_tdata
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready) else $error("tick not taken");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[80] |-> !m_tdata[0] || m_tdata[31])
		else $error("all done while running without completion");
endmodule

bind shortest_remaining_time_scheduler srts_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import srts_pkg::*;

	typedef struct {
		logic        cmd;
		logic [3:0]  slot;
		logic [7:0]  tid;
		logic [15:0] arrival;
		logic [7:0]  burst;
	} job_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [87:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [4:0]   cfg_wdata = '0;

	shortest_remaining_time_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// scheduler shadow state
	logic [7:0]  sh_id [16];
	logic [15:0] sh_arrival [16];
	logic [7:0]  sh_burst [16];
	logic [7:0]  sh_left [16];
	logic        sh_done [16];
	logic        sh_started [16];
	logic [15:0] sh_now;
	logic        sh_last_valid;
	logic [3:0]  sh_last_slot;
	logic [4:0]  sh_count;

	job_t    job_q[$];
	result_t tick_q[$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      beats_in = 0;
	int      beats_out = 0;
	int      out_hold = 0;
	int      in_gap = 0;
	logic    in_fire = 1'b0;
	logic    out_fire = 1'b0;
	logic    long_hold_done = 1'b0;
	logic    no_idle = 1'b0;

	function automatic int run_len();
		return (sh_count > 16) ? 16 : int'(sh_count);
	endfunction

	function automatic logic every_done();
		for (int i = 0; i < run_len(); i++)
			if (!sh_done[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void apply_load(job_t j);
		sh_id[j.slot] = j.tid;
		sh_arrival[j.slot] = j.arrival;
		sh_burst[j.slot] = j.burst;
		sh_left[j.slot] = j.burst;
		for (int i = 0; i < 16; i++) begin
			sh_done[i] = 1'b0;
			sh_started[i] = 1'b0;
		end
		sh_now = '0;
		sh_last_valid = 1'b0;
		sh_last_slot = '0;
	endfunction

	function automatic result_t schedule_tick();
		result_t r;
		logic    found;
		int      sel;
		int      turn;
		r = '0;
		found = 1'b0;
		sel = 0;
		r.tick_time = sh_now;
		if (every_done()) begin
			r.all_done = 1'b1;
			return r;
		end
		for (int i = 0; i < run_len(); i++)
			if (!sh_done[i] && sh_arrival[i] <= sh_now)
				if (!found || sh_left[i] < sh_left[sel]) begin
					sel = i;
					found = 1'b1;
				end
		if (sh_last_valid && (!found || sh_last_slot != sel) && sh_left[sh_last_slot] > 0) begin
			r.preempted = 1'b1;
			r.preempted_id = sh_id[sh_last_slot];
			r.preempted_left = sh_left[sh_last_slot];
		end
		if (!found) begin
			if (sh_now != 16'hFFFF)
				sh_now++;
			sh_last_valid = 1'b0;
		end else begin
			r.running_valid = 1'b1;
			r.running_slot = sel[3:0];
			r.running_id = sh_id[sel];
			if (!sh_started[sel] || !sh_last_valid || sh_last_slot != sel) begin
				r.resumed = 1'b1;
				sh_started[sel] = 1'b1;
			end
			if (sh_left[sel] > 0)
				sh_left[sel]--;
			if (sh_now != 16'hFFFF)
				sh_now++;
			if (sh_left[sel] == 0) begin
				turn = int'(sh_now) - int'(sh_arrival[sel]);
				sh_done[sel] = 1'b1;
				r.completed = 1'b1;
				r.turnaround = turn[15:0];
				r.waiting = (turn >= sh_burst[sel]) ? 16'(turn - sh_burst[sel]) : 16'd0;
			end
			sh_last_valid = 1'b1;
			sh_last_slot = sel[3:0];
		end
		r.all_done = every_done();
		return r;
	endfunction

	function automatic result_t unpack_beat(logic [87:0] d);
		result_t r;
		r.running_valid = d[0];
		r.running_slot = d[4:1];
		r.running_id = d[12:5];
		r.resumed = d[13];
		r.preempted = d[14];
		r.preempted_id = d[22:15];
		r.preempted_left = d[30:23];
		r.completed = d[31];
		r.turnaround = d[47:32];
		r.waiting = d[63:48];
		r.tick_time = d[79:64];
		r.all_done = d[80];
		return r;
	endfunction

	task automatic push_load(logic [3:0] s, logic [7:0] id, logic [15:0] arr, logic [7:0] b);
		job_t j;
		j.cmd = 1'b0;
		j.slot = s;
		j.tid = id;
		j.arrival = arr;
		j.burst = b;
		apply_load(j);
		job_q.push_back(j);
	endtask

	task automatic push_tick();
		job_t j;
		j.cmd = 1'b1;
		j.slot = 4'($urandom);
		j.tid = 8'($urandom);
		j.arrival = 16'($urandom);
		j.burst = 8'($urandom);
		tick_q.push_back(schedule_tick());
		job_q.push_back(j);
	endtask

	task automatic settle();
		while (job_q.size() != 0 || tick_q.size() != 0 || s_tvalid)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_count(logic [4:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_count = v;
	endtask

	// handshake flags, then the sender
	always @(posedge clk) begin
		in_fire <= s_tvalid && s_tready;
		out_fire <= m_tvalid && m_tready;
	end

	always @(negedge clk) begin
		job_t j;
		logic nv;
		nv = s_tvalid;
		if (arst_n && (!s_tvalid || in_fire)) begin
			nv = 1'b0;
			if (in_gap > 0)
				in_gap--;
			else if (job_q.size() != 0) begin
				j = job_q.pop_front();
				s_tdata <= {4'b0, j.burst, j.arrival, j.tid, j.slot};
				s_tuser <= j.cmd;
				nv = 1'b1;
				in_gap = no_idle ? 0 : $urandom_range(0, 17);
			end
		end
		s_tvalid <= nv;
	end

	// receiver stalls, with one long hold-off
	always @(negedge clk) begin
		logic nr;
		nr = m_tready;
		if (arst_n) begin
			if (!long_hold_done && beats_in >= 120) begin
				long_hold_done <= 1'b1;
				out_hold = 400;
			end
			if (out_fire && !no_idle && out_hold == 0)
				out_hold = $urandom_range(0, 17);
			if (out_hold > 0) begin
				out_hold--;
				nr = 1'b0;
			end else
				nr = 1'b1;
		end
		m_tready <= nr;
	end

	// checker and watchdog
	always @(posedge clk) begin
		result_t got;
		result_t want;
		logic    moved;
		moved = 1'b0;
		if (s_tvalid && s_tready) begin
			beats_in++;
			moved = 1'b1;
		end
		if (m_tvalid && m_tready) begin
			moved = 1'b1;
			beats_out++;
			got = unpack_beat(m_tdata);
			if (tick_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat %0d: %h", beats_out, m_tdata);
			end else begin
				want = tick_q.pop_front();
				if (got != want) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch at result beat %0d", beats_out);
						$display("  exp run %b slot %0d id %0d res %b pre %b id %0d left %0d",
							want.running_valid, want.running_slot, want.running_id,
							want.resumed, want.preempted, want.preempted_id,
							want.preempted_left);
						$display("  got run %b slot %0d id %0d res %b pre %b id %0d left %0d",
							got.running_valid, got.running_slot, got.running_id,
							got.resumed, got.preempted, got.preempted_id,
							got.preempted_left);
						$display("  exp cmp %b turn %0d wait %0d time %0d all %b",
							want.completed, want.turnaround, want.waiting,
							want.tick_time, want.all_done);
						$display("  got cmp %b turn %0d wait %0d time %0d all %b",
							got.completed, got.turnaround, got.waiting,
							got.tick_time, got.all_done);
					end
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= 3000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int items;
		int n;
		int ticks;
		for (int i = 0; i < 16; i++) begin
			sh_done[i] = 1'b0;
			sh_started[i] = 1'b0;
		end
		sh_now = '0;
		sh_last_valid = 1'b0;
		sh_last_slot = '0;
		sh_count = 5'd16;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: fill every slot, extremes of the fields
		push_load(4'd0, 8'd0, 16'd0, 8'd3);
		push_load(4'd1, 8'd255, 16'd0, 8'd1);
		push_load(4'd2, 8'h5A, 16'd1, 8'd0);
		push_load(4'd3, 8'hA5, 16'hFFFF, 8'd255);
		for (int i = 4; i < 15; i++)
			push_load(4'(i), 8'(i * 17), 16'(2 + i), 8'(i));
		push_load(4'd15, 8'hF0, 16'd2, 8'd1);
		repeat (8) push_tick();
		set_count(5'd0);
		push_tick();
		set_count(5'd31);
		push_tick();
		set_count(5'd1);
		push_tick();
		push_tick();
		push_tick();
		items = 29;

		while (items < 650) begin
			case ($urandom_range(0, 9))
				0: n = 16;
				1: n = $urandom_range(17, 31);
				2: n = $urandom_range(0, 1);
				default: n = $urandom_range(2, 6);
			endcase
			set_count(5'(n));
			no_idle = ($urandom_range(0, 5) == 0);
			for (int s = 0; s < ((n > 16) ? 16 : n); s++) begin
				push_load(4'(s), 8'($urandom),
					($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)),
					($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10)));
				items++;
			end
			ticks = 0;
			while (!every_done() && ticks < 80) begin
				if ($urandom_range(0, 40) == 0) begin
					push_load(4'($urandom_range(0, 15)), 8'($urandom),
						16'($urandom_range(0, 8)), 8'($urandom_range(1, 6)));
					items++;
				end
				push_tick();
				ticks++;
				items++;
			end
			repeat ($urandom_range(0, 2)) begin
				push_tick();
				items++;
			end
		end

		settle();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
